/* rtl/bounded_damerau_osa_distance_assert.svh */
// Assertion macros used by the bounded OSA distance top level.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef BOUNDED_DAMERAU_OSA_DISTANCE_ASSERT_SVH
`define BOUNDED_DAMERAU_OSA_DISTANCE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDOD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bdod_pkg.sv */
// Shared constants and types for the bounded OSA distance block.
// No dependencies; used by bdod_cell, the top level and the bench.
package bdod_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int CHAR_W      = 8;
    localparam int DIST_W      = 7;
    localparam int CFG_W       = 8;

    localparam logic CMD_BASE  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic init;   // load the first-row costs and clear the back row
        logic shift;  // move the text characters one cell along
    } cell_ctrl_t;

endpackage

/* rtl/bdod_cell.sv */
// One column of the banded OSA table: holds a text character and the
// current and previous row entries of its column. Depends on bdod_pkg.
module bdod_cell #(
    parameter int MAX_LEN = bdod_pkg::MAX_LEN_DEF,
    parameter int IDX     = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bdod_pkg::cell_ctrl_t           ctrl,
    input  logic [$clog2(MAX_LEN+1)-1:0]   lim,
    input  logic [bdod_pkg::CHAR_W-1:0]    t0_char,
    input  logic [bdod_pkg::CHAR_W-1:0]    ch_in,
    input  logic                           tok_v_in,
    input  logic [$clog2(MAX_LEN+1)-1:0]   tok_i_in,
    input  logic [bdod_pkg::CHAR_W-1:0]    tok_sc_in,
    input  logic [bdod_pkg::CHAR_W-1:0]    tok_ps_in,
    input  logic [$clog2(MAX_LEN+1)-1:0]   tok_js_in,
    input  logic [$clog2(MAX_LEN+1)-1:0]   tok_je_in,
    input  logic [$clog2(MAX_LEN+1)-1:0]   tok_chk_in,
    input  logic                           tok_last_in,
    input  logic                           tok_ovr_in,
    input  logic [$clog2(MAX_LEN+1):0]     tok_res_in,
    input  logic [$clog2(MAX_LEN+1):0]     cur_in,
    input  logic [$clog2(MAX_LEN+1):0]     left_in,
    input  logic [$clog2(MAX_LEN+1):0]     trans_in,
    output logic [bdod_pkg::CHAR_W-1:0]    ch_out,
    output logic                           tok_v_out,
    output logic [$clog2(MAX_LEN+1)-1:0]   tok_i_out,
    output logic [bdod_pkg::CHAR_W-1:0]    tok_sc_out,
    output logic [bdod_pkg::CHAR_W-1:0]    tok_ps_out,
    output logic [$clog2(MAX_LEN+1)-1:0]   tok_js_out,
    output logic [$clog2(MAX_LEN+1)-1:0]   tok_je_out,
    output logic [$clog2(MAX_LEN+1)-1:0]   tok_chk_out,
    output logic                           tok_last_out,
    output logic                           tok_ovr_out,
    output logic [$clog2(MAX_LEN+1):0]     tok_res_out,
    output logic [$clog2(MAX_LEN+1):0]     cur_out,
    output logic [$clog2(MAX_LEN+1):0]     left_out,
    output logic [$clog2(MAX_LEN+1):0]     trans_out
);

    localparam int LW = $clog2(MAX_LEN+1);
    localparam int CW = LW + 1;
    localparam logic [LW-1:0] JV = LW'(IDX);

    logic [bdod_pkg::CHAR_W-1:0] ch_reg;
    logic [CW-1:0] cost_reg, back_reg;
    logic          tok_v_reg;
    logic [LW-1:0] tok_i_reg, tok_js_reg, tok_je_reg, tok_chk_reg;
    logic [bdod_pkg::CHAR_W-1:0] tok_sc_reg, tok_ps_reg;
    logic          tok_last_reg, tok_ovr_reg;
    logic [CW-1:0] tok_res_reg, cur_reg, left_reg, trans_reg;

    logic          at_start, in_band, is_end;
    logic [CW-1:0] above, diag, trans, step, cost_new, cost_row;
    logic [CW-1:0] cost_next, back_next, res_next;
    logic [bdod_pkg::CHAR_W-1:0] prev_t;
    logic          ovr_next;

    always_comb begin
        at_start = (JV == tok_js_in);
        in_band  = tok_v_in && (JV >= tok_js_in) && (JV < tok_je_in);
        // The first column of a band restarts from the row index.
        above    = at_start ? CW'(tok_i_in) + CW'(1) : cur_in;
        diag     = at_start ? CW'(tok_i_in) : left_in;
        trans    = at_start ? '0 : trans_in;
        prev_t   = at_start ? t0_char : ch_in;

        step = diag;
        if (cost_reg < step) step = cost_reg;
        if (above < step) step = above;
        step = step + CW'(1);
        if ((tok_i_in != '0) && (JV != '0) && (tok_sc_in == prev_t) &&
            (tok_ps_in == ch_reg) && ((trans + CW'(1)) < step)) begin
            step = trans + CW'(1);
        end
        cost_new = (tok_sc_in == ch_reg) ? diag : step;
        cost_row = in_band ? cost_new : cost_reg;

        if (ctrl.init) begin
            cost_next = (JV < lim) ? CW'(IDX) + CW'(1) : CW'(lim) + CW'(1);
            back_next = '0;
        end else begin
            cost_next = cost_row;
            back_next = in_band ? diag : back_reg;
        end

        ovr_next = tok_ovr_in | (tok_v_in && (JV == tok_chk_in) && (cost_row > CW'(lim)));
        is_end   = tok_v_in && tok_last_in && (({1'b0, JV} + CW'(1)) == {1'b0, tok_je_in});
        res_next = is_end ? cost_new : tok_res_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_v_reg <= 1'b0;
        end else begin
            tok_v_reg <= tok_v_in;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg       <= ctrl.shift ? ch_in : ch_reg;
        cost_reg     <= cost_next;
        back_reg     <= back_next;
        tok_i_reg    <= tok_i_in;
        tok_sc_reg   <= tok_sc_in;
        tok_ps_reg   <= tok_ps_in;
        tok_js_reg   <= tok_js_in;
        tok_je_reg   <= tok_je_in;
        tok_chk_reg  <= tok_chk_in;
        tok_last_reg <= tok_last_in;
        tok_ovr_reg  <= ovr_next;
        tok_res_reg  <= res_next;
        cur_reg      <= cost_row;
        left_reg     <= cost_reg;
        trans_reg    <= back_reg;
    end

    assign ch_out       = ch_reg;
    assign tok_v_out    = tok_v_reg;
    assign tok_i_out    = tok_i_reg;
    assign tok_sc_out   = tok_sc_reg;
    assign tok_ps_out   = tok_ps_reg;
    assign tok_js_out   = tok_js_reg;
    assign tok_je_out   = tok_je_reg;
    assign tok_chk_out  = tok_chk_reg;
    assign tok_last_out = tok_last_reg;
    assign tok_ovr_out  = tok_ovr_reg;
    assign tok_res_out  = tok_res_reg;
    assign cur_out      = cur_reg;
    assign left_out     = left_reg;
    assign trans_out    = trans_reg;

endmodule

/* rtl/bounded_damerau_osa_distance.sv */
// After the final query character the common suffix and prefix are trimmed, comparing one
// character pair at a time through the memory read ports (a read state, then a compare state);
// then the text is shifted into the cell row one char a cycle, and rows ripple through MAX_LEN
// cells before the result loads into the output register.
// Throughput: one input transaction a cycle; input holds off from the final query character
// until the result loads. Reset (synchronous, aresetn low): strings empty, cutoff -1, idle.
module bounded_damerau_osa_distance #(
    parameter int MAX_LEN = bdod_pkg::MAX_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wren,
    input  logic [bdod_pkg::CFG_W-1:0]     cfg_wdata,   // max_distance, signed
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,     // [7:0] char_code
    input  logic [1:0]                     s_tuser,     // [0] command, [1] no_char
    input  logic                           s_tlast,     // last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,     // [6:0] distance, [7] zero
    output logic                           m_tuser      // [0] over_limit
);

`include "bounded_damerau_osa_distance_assert.svh"

    localparam int LW   = $clog2(MAX_LEN+1);   // lengths 0..MAX_LEN
    localparam int IW   = $clog2(MAX_LEN);     // memory index
    localparam int CW   = LW + 1;              // table entries
    localparam int CMPW = (LW > 8) ? LW : 8;
    localparam int CHW  = bdod_pkg::CHAR_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_SUF_RD, ST_SUF_CMP, ST_PRE_RD, ST_PRE_CMP,
        ST_PRE_END, ST_LIM, ST_INIT, ST_LOAD, ST_ROWS, ST_DRAIN, ST_DONE
    } state_t;

    state_t state_reg;

    // Configuration and string bookkeeping
    logic [bdod_pkg::CFG_W-1:0] cfg_reg;
    logic [LW-1:0] base_len_reg, query_len_reg;
    logic          base_closed_reg, query_closed_reg;

    logic [CHW-1:0] base_mem  [MAX_LEN];
    logic [CHW-1:0] query_mem [MAX_LEN];
    logic [CHW-1:0] base_q_reg, query_q_reg;

    // Sequencer registers
    logic          swap_reg, havemax_reg, over_acc_reg, ovr_reg;
    logic [LW-1:0] slen_reg, tlen_reg, start_reg, lim_reg, ldiff_reg;
    logic [LW-1:0] k_reg, i_reg, row_i_reg, jstart_reg, jend_reg;
    logic          rd_v_reg, row_v_reg;
    logic [CHW-1:0] prev_sc_reg;
    logic [CW-1:0] res_reg;

    // Token entering the first cell
    logic          tok0_v_reg, tok0_last_reg;
    logic [LW-1:0] tok0_i_reg, tok0_js_reg, tok0_je_reg, tok0_chk_reg;
    logic [CHW-1:0] tok0_sc_reg, tok0_ps_reg;

    // Output register
    logic          m_tvalid_reg, m_over_reg;
    logic [bdod_pkg::DIST_W-1:0] m_dist_reg;

    // Input decode
    logic          acc, is_q, empty, lst, closed, fits;
    logic [LW-1:0] len_now, len_new;
    logic [IW-1:0] wr_addr;

    // Read addressing
    logic [LW-1:0] s_addr, t_addr;
    logic [IW-1:0] base_rd, query_rd;
    logic [CHW-1:0] s_q, t_q;

    // Limit evaluation
    logic          mx_neg;
    logic [CMPW-1:0] mx_c, tl_c, ld_c;
    logic [LW-1:0] ld_w, offset, js_new, je_new;

    // Cell row wiring
    bdod_pkg::cell_ctrl_t ctrl;
    logic [CHW-1:0] ch_w    [MAX_LEN+1];
    logic           v_w     [MAX_LEN+1];
    logic [LW-1:0]  i_w     [MAX_LEN+1];
    logic [CHW-1:0] sc_w    [MAX_LEN+1];
    logic [CHW-1:0] ps_w    [MAX_LEN+1];
    logic [LW-1:0]  js_w    [MAX_LEN+1];
    logic [LW-1:0]  je_w    [MAX_LEN+1];
    logic [LW-1:0]  chk_w   [MAX_LEN+1];
    logic           last_w  [MAX_LEN+1];
    logic           ovr_w   [MAX_LEN+1];
    logic [CW-1:0]  res_w   [MAX_LEN+1];
    logic [CW-1:0]  cur_w   [MAX_LEN+1];
    logic [CW-1:0]  left_w  [MAX_LEN+1];
    logic [CW-1:0]  trans_w [MAX_LEN+1];

    logic exit_v, exit_last, exit_ovr;
    logic [CW-1:0] exit_res;

    // ------------------------------------------------------------------
    // Input transactions: append to the base or query string
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign is_q     = (s_tuser[0] == bdod_pkg::CMD_QUERY);
    assign empty    = s_tuser[1];
    assign lst      = empty | s_tlast;   // an empty string always closes

    always_comb begin
        closed  = is_q ? query_closed_reg : base_closed_reg;
        len_now = (closed || empty) ? '0 : (is_q ? query_len_reg : base_len_reg);
        fits    = !empty && (len_now < LW'(MAX_LEN));
        // Characters past MAX_LEN are dropped and the length saturates.
        len_new = fits ? len_now + LW'(1) : len_now;
        wr_addr = len_now[IW-1:0];
    end

    // ------------------------------------------------------------------
    // Memory read addresses; s is the shorter string, t the longer
    // ------------------------------------------------------------------
    always_comb begin
        s_addr = '0;
        t_addr = '0;
        unique case (state_reg)
            ST_SUF_RD: begin
                s_addr = slen_reg - LW'(1);
                t_addr = tlen_reg - LW'(1);
            end
            ST_PRE_RD: begin
                s_addr = start_reg;
                t_addr = start_reg;
            end
            // Feed the text last character first so it ends up aligned in the row.
            ST_LOAD: t_addr = start_reg + tlen_reg - LW'(1) - k_reg;
            ST_ROWS: s_addr = start_reg + i_reg;
            default: begin
                s_addr = '0;
                t_addr = '0;
            end
        endcase
        base_rd  = swap_reg ? t_addr[IW-1:0] : s_addr[IW-1:0];
        query_rd = swap_reg ? s_addr[IW-1:0] : t_addr[IW-1:0];
        s_q      = swap_reg ? query_q_reg : base_q_reg;
        t_q      = swap_reg ? base_q_reg : query_q_reg;
    end

    always_ff @(posedge aclk) begin
        if (acc && fits && !is_q) base_mem[wr_addr] <= s_tdata;
        if (acc && fits && is_q) query_mem[wr_addr] <= s_tdata;
        base_q_reg  <= base_mem[base_rd];
        query_q_reg <= query_mem[query_rd];
    end

    // ------------------------------------------------------------------
    // Cutoff and band bounds
    // ------------------------------------------------------------------
    always_comb begin
        mx_neg = cfg_reg[bdod_pkg::CFG_W-1];
        mx_c   = CMPW'(cfg_reg[bdod_pkg::CFG_W-2:0]);
        tl_c   = CMPW'(tlen_reg);
        ld_w   = tlen_reg - slen_reg;
        ld_c   = CMPW'(ld_w);
        offset = lim_reg - ldiff_reg;
        // Band moves right once the row passes the offset; end widens up to tLen.
        js_new = jstart_reg + ((row_i_reg > offset) ? LW'(1) : LW'(0));
        je_new = jend_reg + ((jend_reg < tlen_reg) ? LW'(1) : LW'(0));
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cfg_reg          <= '1;
            base_len_reg     <= '0;
            query_len_reg    <= '0;
            base_closed_reg  <= 1'b1;
            query_closed_reg <= 1'b1;
            rd_v_reg         <= 1'b0;
            row_v_reg        <= 1'b0;
            tok0_v_reg       <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            swap_reg         <= 1'b0;
        end else begin
            if (cfg_wren) cfg_reg <= cfg_wdata;
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            rd_v_reg   <= 1'b0;
            row_v_reg  <= 1'b0;
            tok0_v_reg <= 1'b0;

            // Form each row transaction in the cycle after its s character is read.
            if (row_v_reg) begin
                tok0_v_reg    <= 1'b1;
                tok0_i_reg    <= row_i_reg;
                tok0_sc_reg   <= s_q;
                tok0_ps_reg   <= prev_sc_reg;
                tok0_js_reg   <= js_new;
                tok0_je_reg   <= je_new;
                tok0_chk_reg  <= row_i_reg + ldiff_reg;
                tok0_last_reg <= (row_i_reg == slen_reg - LW'(1));
                prev_sc_reg   <= s_q;
                jstart_reg    <= js_new;
                jend_reg      <= je_new;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        if (is_q) begin
                            query_len_reg    <= len_new;
                            query_closed_reg <= lst;
                        end else begin
                            base_len_reg    <= len_new;
                            base_closed_reg <= lst;
                        end
                        if (is_q && lst) state_reg <= ST_START;
                    end
                end
                ST_START: begin
                    ovr_reg   <= 1'b0;
                    start_reg <= '0;
                    // Empty strings answer with the other length, no limit check.
                    if (base_len_reg == '0) begin
                        res_reg   <= CW'(query_len_reg);
                        state_reg <= ST_DONE;
                    end else if (query_len_reg == '0) begin
                        res_reg   <= CW'(base_len_reg);
                        state_reg <= ST_DONE;
                    end else begin
                        swap_reg  <= (base_len_reg > query_len_reg);
                        slen_reg  <= (base_len_reg > query_len_reg) ? query_len_reg
                                                                     : base_len_reg;
                        tlen_reg  <= (base_len_reg > query_len_reg) ? base_len_reg
                                                                     : query_len_reg;
                        state_reg <= ST_SUF_RD;
                    end
                end
                ST_SUF_RD: begin
                    state_reg <= (slen_reg == '0) ? ST_PRE_RD : ST_SUF_CMP;
                end
                ST_SUF_CMP: begin
                    if (s_q == t_q) begin
                        slen_reg  <= slen_reg - LW'(1);
                        tlen_reg  <= tlen_reg - LW'(1);
                        state_reg <= ST_SUF_RD;
                    end else begin
                        state_reg <= ST_PRE_RD;
                    end
                end
                ST_PRE_RD: begin
                    state_reg <= (start_reg == slen_reg) ? ST_PRE_END : ST_PRE_CMP;
                end
                ST_PRE_CMP: begin
                    if (s_q == t_q) begin
                        start_reg <= start_reg + LW'(1);
                        state_reg <= ST_PRE_RD;
                    end else begin
                        state_reg <= ST_PRE_END;
                    end
                end
                ST_PRE_END: begin
                    slen_reg  <= slen_reg - start_reg;
                    tlen_reg  <= tlen_reg - start_reg;
                    state_reg <= ST_LIM;
                end
                ST_LIM: begin
                    ldiff_reg <= ld_w;
                    if (slen_reg == '0) begin
                        // Shorter string fully matched: rest of the longer one, unchecked.
                        res_reg   <= CW'(tlen_reg);
                        state_reg <= ST_DONE;
                    end else if (mx_neg || (mx_c > tl_c)) begin
                        lim_reg     <= tlen_reg;
                        havemax_reg <= 1'b0;
                        state_reg   <= ST_INIT;
                    end else if (ld_c > mx_c) begin
                        res_reg   <= '0;
                        ovr_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        lim_reg     <= LW'(mx_c);
                        havemax_reg <= (mx_c < tl_c);
                        state_reg   <= ST_INIT;
                    end
                end
                ST_INIT: begin
                    k_reg        <= '0;
                    i_reg        <= '0;
                    jstart_reg   <= '0;
                    jend_reg     <= lim_reg;
                    over_acc_reg <= 1'b0;
                    state_reg    <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (k_reg < tlen_reg) begin
                        rd_v_reg <= 1'b1;
                        k_reg    <= k_reg + LW'(1);
                    end else begin
                        state_reg <= ST_ROWS;
                    end
                end
                ST_ROWS: begin
                    if (i_reg < slen_reg) begin
                        row_v_reg <= 1'b1;
                        row_i_reg <= i_reg;
                        i_reg     <= i_reg + LW'(1);
                    end else begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (exit_v) begin
                        over_acc_reg <= over_acc_reg | exit_ovr;
                        if (exit_last) begin
                            res_reg   <= exit_res;
                            ovr_reg   <= (havemax_reg && (over_acc_reg || exit_ovr)) ||
                                         (exit_res > CW'(lim_reg));
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    // Hold until the output register is free.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_over_reg   <= ovr_reg;
                        m_dist_reg   <= ovr_reg ? '0 : bdod_pkg::DIST_W'(res_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cell row: column j of the band lives in cell j
    // ------------------------------------------------------------------
    assign ctrl.init  = (state_reg == ST_INIT);
    assign ctrl.shift = rd_v_reg;

    assign ch_w[0]    = t_q;
    assign v_w[0]     = tok0_v_reg;
    assign i_w[0]     = tok0_i_reg;
    assign sc_w[0]    = tok0_sc_reg;
    assign ps_w[0]    = tok0_ps_reg;
    assign js_w[0]    = tok0_js_reg;
    assign je_w[0]    = tok0_je_reg;
    assign chk_w[0]   = tok0_chk_reg;
    assign last_w[0]  = tok0_last_reg;
    assign ovr_w[0]   = 1'b0;
    assign res_w[0]   = '0;
    assign cur_w[0]   = '0;
    assign left_w[0]  = '0;
    assign trans_w[0] = '0;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        bdod_cell #(
            .MAX_LEN (MAX_LEN),
            .IDX     (g)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (ctrl),
            .lim          (lim_reg),
            .t0_char      (ch_w[1]),
            .ch_in        (ch_w[g]),
            .tok_v_in     (v_w[g]),
            .tok_i_in     (i_w[g]),
            .tok_sc_in    (sc_w[g]),
            .tok_ps_in    (ps_w[g]),
            .tok_js_in    (js_w[g]),
            .tok_je_in    (je_w[g]),
            .tok_chk_in   (chk_w[g]),
            .tok_last_in  (last_w[g]),
            .tok_ovr_in   (ovr_w[g]),
            .tok_res_in   (res_w[g]),
            .cur_in       (cur_w[g]),
            .left_in      (left_w[g]),
            .trans_in     (trans_w[g]),
            .ch_out       (ch_w[g+1]),
            .tok_v_out    (v_w[g+1]),
            .tok_i_out    (i_w[g+1]),
            .tok_sc_out   (sc_w[g+1]),
            .tok_ps_out   (ps_w[g+1]),
            .tok_js_out   (js_w[g+1]),
            .tok_je_out   (je_w[g+1]),
            .tok_chk_out  (chk_w[g+1]),
            .tok_last_out (last_w[g+1]),
            .tok_ovr_out  (ovr_w[g+1]),
            .tok_res_out  (res_w[g+1]),
            .cur_out      (cur_w[g+1]),
            .left_out     (left_w[g+1]),
            .trans_out    (trans_w[g+1])
        );
    end

    assign exit_v    = v_w[MAX_LEN];
    assign exit_last = last_w[MAX_LEN];
    assign exit_ovr  = ovr_w[MAX_LEN];
    assign exit_res  = res_w[MAX_LEN];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_dist_reg};
    assign m_tuser  = m_over_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BDOD_ASSERT_NEXT(a_done_loads, (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready), m_tvalid_reg, "result not loaded")
    `BDOD_ASSERT_SAME(a_over_zero, m_tvalid_reg && m_over_reg, m_dist_reg == '0, "distance not zero on over_limit")
    `BDOD_ASSERT_SAME(a_exit_drain, exit_v && exit_last, state_reg == ST_DRAIN, "final row outside drain")
    `BDOD_ASSERT_SAME(a_tok_phase, tok0_v_reg, (state_reg == ST_ROWS) || (state_reg == ST_DRAIN), "row issued outside row phase")

endmodule

/* bench/bounded_damerau_osa_distance_test.sv */
// Self-checking bench for bounded_damerau_osa_distance: directed cases, random strings and edited queries.
// It predicts each OSA distance in place and compares it with the result stream.
// Depends on bdod_pkg and the RTL top level only.

module bounded_damerau_osa_distance_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_CAP    = bdod_pkg::MAX_LEN_DEF;
    // Extra settling wait at the end of each drain, with margin.
    localparam int DRAIN_WAIT = 450;

    typedef struct {
        logic       cmd;
        logic [7:0] code;
        logic       no_char;
        logic       last;
    } char_item_t;

    typedef struct {
        logic [6:0] distance;
        logic       over_limit;
    } osa_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wren = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;

    bounded_damerau_osa_distance DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wren(cfg_wren), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the block state: strings follow every accepted input transaction, the cutoff each write.
    int          cutoff = -1;
    logic [7:0]  base_str[LEN_CAP];
    logic [7:0]  query_str[LEN_CAP];
    int          base_len = 0;
    int          query_len = 0;
    bit          base_done = 1'b1;
    bit          query_done = 1'b1;

    char_item_t  pending_chars[$];
    osa_result_t expected_dists[$];
    bit          calm = 1'b0;     // suppress random idling on both sides
    bit          failed = 1'b0;
    int          item_count = 0;

    // Banded two-row OSA distance with cutoff; returns -1 above the cutoff.
    function automatic int osa_distance(int limit);
        logic [7:0] s[LEN_CAP];
        logic [7:0] t[LEN_CAP];
        int cost[LEN_CAP];
        int back[LEN_CAP];
        int s_len, t_len, start, len_diff, j_off, j_lo, j_hi, cur;
        int left, above, trans, next_trans;
        bit have_max;
        logic [7:0] sc, prev_s, tc, prev_t;
        if (base_len == 0) return query_len;
        if (query_len == 0) return base_len;
        if (base_len > query_len) begin
            s = query_str; s_len = query_len;
            t = base_str;  t_len = base_len;
        end else begin
            s = base_str;  s_len = base_len;
            t = query_str; t_len = query_len;
        end
        // strip common suffix, then common prefix
        while (s_len > 0 && s[s_len-1] == t[t_len-1]) begin
            s_len--;
            t_len--;
        end
        start = 0;
        if (s_len == 0 || s[0] == t[0]) begin
            while (start < s_len && s[start] == t[start]) start++;
            s_len -= start;
            t_len -= start;
            if (s_len == 0) return t_len;
        end
        len_diff = t_len - s_len;
        if (limit < 0 || limit > t_len) limit = t_len;
        else if (len_diff > limit) return -1;
        for (int j = 0; j < t_len; j++) begin
            back[j] = 0;
            cost[j] = (j < limit) ? j + 1 : limit + 1;
        end
        j_off = limit - len_diff;
        have_max = limit < t_len;
        j_lo = 0;
        j_hi = limit;
        sc = s[0];
        cur = 0;
        for (int i = 0; i < s_len; i++) begin
            prev_s = sc;
            tc = t[start];
            left = i;
            next_trans = 0;
            sc = s[start+i];
            cur = left + 1;
            if (i > j_off) j_lo++;
            if (j_hi < t_len) j_hi++;
            for (int j = j_lo; j < j_hi; j++) begin
                above = cur;
                trans = next_trans;
                prev_t = tc;
                next_trans = back[j];
                cur = left;
                back[j] = cur;
                left = cost[j];
                tc = t[start+j];
                if (sc != tc) begin
                    if (left < cur) cur = left;
                    if (above < cur) cur = above;
                    cur++;
                    if (i != 0 && j != 0 && sc == prev_t && prev_s == tc) begin
                        trans++;
                        if (trans < cur) cur = trans;
                    end
                end
                cost[j] = cur;
            end
            if (have_max && cost[i+len_diff] > limit) return -1;
        end
        return (cur <= limit) ? cur : -1;
    endfunction

    // Fold one accepted character into the shadow strings; queue a result on query end.
    function automatic void absorb_char(char_item_t it);
        bit ends;
        int d;
        osa_result_t r;
        ends = it.last || it.no_char;
        if (it.cmd == bdod_pkg::CMD_QUERY) begin
            if (query_done || it.no_char) query_len = 0;
            if (!it.no_char && query_len < LEN_CAP) begin
                query_str[query_len] = it.code;
                query_len++;
            end
            query_done = ends;
        end else begin
            if (base_done || it.no_char) base_len = 0;
            if (!it.no_char && base_len < LEN_CAP) begin
                base_str[base_len] = it.code;
                base_len++;
            end
            base_done = ends;
        end
        if (it.cmd == bdod_pkg::CMD_QUERY && ends) begin
            d = osa_distance(cutoff);
            r.over_limit = (d < 0);
            r.distance = (d < 0) ? 7'd0 : 7'(d);
            expected_dists.push_back(r);
        end
    endfunction

    // Driver: predict on acceptance, then advance to the next pending item or idle.
    always @(posedge aclk) begin
        char_item_t it;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                it.cmd = s_tuser[0];
                it.no_char = s_tuser[1];
                it.code = s_tdata;
                it.last = s_tlast;
                absorb_char(it);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_chars.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
                    it = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= it.code;
                    s_tuser <= {it.no_char, it.cmd};
                    s_tlast <= it.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        osa_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_dists.size() == 0) begin
                    $display("%0t: unexpected result distance=%0d over_limit=%0b",
                             $time, m_tdata[6:0], m_tuser);
                    failed = 1'b1;
                end else begin
                    want = expected_dists.pop_front();
                    if (m_tdata[6:0] !== want.distance) begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, want.distance, m_tdata[6:0]);
                        failed = 1'b1;
                    end
                    if (m_tuser !== want.over_limit) begin
                        $display("%0t: over_limit expected %0b actual %0b",
                                 $time, want.over_limit, m_tuser);
                        failed = 1'b1;
                    end
                end
            end
            m_tready <= calm || $urandom_range(99) >= 6;
        end
    end

    task automatic push_char(logic cmd, logic [7:0] code, logic no_char, logic last);
        char_item_t it;
        it.cmd = cmd;
        it.code = code;
        it.no_char = no_char;
        it.last = last;
        pending_chars.push_back(it);
        item_count++;
    endtask

    // Queue a whole string; an empty one goes as a single no_char transaction.
    task automatic push_string(logic cmd, logic [7:0] str[$]);
        if (str.size() == 0) begin
            push_char(cmd, 8'($urandom), 1'b1, 1'($urandom));
        end else begin
            foreach (str[k]) push_char(cmd, str[k], 1'b0, k == str.size() - 1);
        end
    endtask

    function automatic logic [7:0] pick_char();
        // mostly a tiny alphabet so that matches and transpositions are common
        if ($urandom_range(9) < 8) return 8'h61 + 8'($urandom_range(3));
        return 8'($urandom);
    endfunction

    function automatic int pick_len();
        if ($urandom_range(99) < 3) return $urandom_range(72, 40);
        return $urandom_range(12);
    endfunction

    // Apply a few random edits: substitute, insert, delete, swap neighbors.
    function automatic void mutate(ref logic [7:0] str[$]);
        int n, p;
        logic [7:0] tmp;
        n = $urandom_range(4);
        repeat (n) begin
            p = (str.size() > 0) ? $urandom_range(str.size() - 1) : 0;
            case ($urandom_range(3))
                0: if (str.size() > 0) str[p] = pick_char();
                1: str.insert(p, pick_char());
                2: if (str.size() > 0) str.delete(p);
                default: if (str.size() > 1 && p > 0) begin
                    tmp = str[p];
                    str[p] = str[p-1];
                    str[p-1] = tmp;
                end
            endcase
        end
    endfunction

    // Hold off until every expected result is back and the block has settled.
    task automatic drain();
        do @(posedge aclk);
        while (pending_chars.size() > 0 || s_tvalid || expected_dists.size() > 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_cutoff(int value);
        cfg_wren <= 1'b1;
        cfg_wdata <= 8'(value);
        cutoff = $signed(8'(value));
        @(posedge aclk);
        cfg_wren <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic directed_run();
        logic [7:0] b[$];
        logic [7:0] q[$];
        b = '{8'h61, 8'h62};       q = '{8'h62, 8'h61};        // transposition
        push_string(bdod_pkg::CMD_BASE, b);  push_string(bdod_pkg::CMD_QUERY, q);
        q = '{8'h00, 8'hFF, 8'h61};
        push_string(bdod_pkg::CMD_QUERY, q);                    // extreme bytes
        q = {};
        push_string(bdod_pkg::CMD_QUERY, q);                    // empty query
        push_string(bdod_pkg::CMD_BASE, q);                     // empty base
        q = '{8'h63, 8'h64, 8'h65};
        push_string(bdod_pkg::CMD_QUERY, q);
        b = '{8'h61, 8'h62, 8'h63}; q = '{8'h61, 8'h78, 8'h62, 8'h63};
        push_string(bdod_pkg::CMD_BASE, b);                     // shorter fully matched
        push_string(bdod_pkg::CMD_QUERY, q);
        q = '{8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A, 8'h7A};
        push_string(bdod_pkg::CMD_QUERY, q);                    // length gap vs cutoff
        // base reloaded while a query is open
        push_char(bdod_pkg::CMD_QUERY, 8'h61, 1'b0, 1'b0);
        push_char(bdod_pkg::CMD_BASE, 8'h62, 1'b0, 1'b1);
        push_char(bdod_pkg::CMD_QUERY, 8'hFF, 1'b0, 1'b1);
        // no_char with last low still closes the string
        push_char(bdod_pkg::CMD_QUERY, 8'h55, 1'b1, 1'b0);
    endtask

    task automatic random_run(int upto);
        logic [7:0] b[$];
        logic [7:0] q[$];
        int n;
        while (item_count < upto) begin
            case ($urandom_range(19))
                0, 1, 2: begin                                  // noise transactions
                    repeat ($urandom_range(4, 1))
                        push_char(1'($urandom), 8'($urandom), $urandom_range(9) == 0,
                                  1'($urandom));
                end
                3, 4, 5: begin                                  // new query, same base
                    q = b;
                    mutate(q);
                    push_string(bdod_pkg::CMD_QUERY, q);
                end
                default: begin
                    b = {};
                    n = pick_len();
                    repeat (n) b.push_back(pick_char());
                    q = b;
                    if ($urandom_range(9) == 0) begin
                        q = {};
                        repeat (pick_len()) q.push_back(pick_char());
                    end else begin
                        mutate(q);
                    end
                    push_string(bdod_pkg::CMD_BASE, b);
                    push_string(bdod_pkg::CMD_QUERY, q);
                end
            endcase
        end
    endtask

    initial begin
        int cutoffs[7] = '{0, 1, 3, 64, -1, 127, -128};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_run();
        drain();
        foreach (cutoffs[k]) begin
            write_cutoff(cutoffs[k]);
            if (k == 0) directed_run();
            calm = (k == 3);
            random_run(item_count + 120);
            drain();
        end
        calm = 1'b0;
        if (failed) begin
            $display("TEST FAILED");
        end else begin
            $display("TEST PASSED");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
